// ----- src/ledcdr_pkg.sv -----
// Package for the LED current deadband regulator.
// Holds the transaction payload types, operation codes and register constants.
// No dependencies.
package ledcdr_pkg;

  // Operation codes carried by a command transaction
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ENC    = 2'd1,
    OP_SERIAL = 2'd2,
    OP_RAW    = 2'd3
  } op_t;

  // Serial bytes that act on the setpoint
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Field widths
  localparam int unsigned CurW  = 10;
  localparam int unsigned DutyW = 9;
  localparam int unsigned StepW = 6;

  // Band = setpoint / 20, done as (setpoint * 3277) >> 16; exact for 10-bit setpoints
  localparam int unsigned  BandProdW  = 22;
  localparam logic [11:0]  BAND_RECIP = 12'd3277;

  // Setpoint ceiling
  localparam logic [CurW-1:0] SP_MAX = 10'd1023;

  // Register indexes on the APB port (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_PANIC_THRESHOLD = 3'd0,
    REG_ENCODER_LIMIT   = 3'd1,
    REG_SERIAL_LIMIT    = 3'd2,
    REG_SERIAL_STEP     = 3'd3,
    REG_MIN_BAND        = 3'd4
  } reg_idx_t;

  // Reset values
  localparam logic [CurW-1:0]  PANIC_THRESHOLD_RST = 10'd973;
  localparam logic [CurW-1:0]  ENCODER_LIMIT_RST   = 10'd400;
  localparam logic [CurW-1:0]  SERIAL_LIMIT_RST    = 10'd500;
  localparam logic [StepW-1:0] SERIAL_STEP_RST     = 6'd10;
  localparam logic [StepW-1:0] MIN_BAND_RST        = 6'd2;
  localparam logic [CurW-1:0]  SETPOINT_RST        = 10'd10;
  localparam logic [DutyW-1:0] DUTY_RST            = 9'd0;

  // Command transaction payload
  typedef struct packed {
    op_t             op;
    logic            up;
    logic [7:0]      rx_byte;
    logic [CurW-1:0] current;
    logic [CurW-1:0] raw_current;
  } cmd_t;

  // Response transaction payload
  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             pwm_on;
    logic [CurW-1:0]  setpoint_out;
  } rsp_t;

endpackage

// ----- src/ledcdr_if.sv -----
// Valid/ready channel interfaces for the LED current deadband regulator.
// Command channel carries one input item, response channel one result item.
// Depends on ledcdr_pkg.
interface ledcdr_cmd_if import ledcdr_pkg::*; ();
  logic            valid;
  logic            ready;
  op_t             op;
  logic            up;
  logic [7:0]      rx_byte;
  logic [CurW-1:0] current;
  logic [CurW-1:0] raw_current;

  modport source (output valid, output op, output up, output rx_byte, output current,
                  output raw_current, input ready);
  modport sink (input valid, input op, input up, input rx_byte, input current,
                input raw_current, output ready);
endinterface

interface ledcdr_rsp_if import ledcdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] duty;
  logic             pwm_on;
  logic [CurW-1:0]  setpoint_out;

  modport source (output valid, output duty, output pwm_on, output setpoint_out, input ready);
  modport sink (input valid, input duty, input pwm_on, input setpoint_out, output ready);
endinterface

// ----- src/led_current_deadband_regulator.sv -----
// LED current deadband regulator: setpoint and PWM duty state machine with APB registers.
// Depends on ledcdr_pkg and the channel interfaces in ledcdr_if.sv.

// The block takes one command transaction per cycle unless stalled and returns
// exactly one response per command. A command is first captured in an input
// register; once the response register can advance, a single pass of compare
// and add logic updates the setpoint and duty registers and loads the response
// register. The band (setpoint / 20, floored at min_band) is formed by a small
// constant multiply. Both registers stall together when the response is not taken,
// so throughput is one item per clock while the sink keeps ready high. Configuration
// registers are written over APB (byte address 4 * index) and must only be changed
// while no command is in flight; pready is always high.
module led_current_deadband_regulator
  import ledcdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ledcdr_cmd_if.sink        cmd,
  ledcdr_rsp_if.source      rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic [CurW-1:0]  panic_threshold;
  logic [CurW-1:0]  encoder_limit;
  logic [CurW-1:0]  serial_limit;
  logic [StepW-1:0] serial_step;
  logic [StepW-1:0] min_band;

  // Regulator state
  logic [CurW-1:0]  setpoint;
  logic [CurW-1:0]  setpoint_next;
  logic [DutyW-1:0] duty;
  logic [DutyW-1:0] duty_next;

  // Pipeline registers
  logic hold_valid;
  cmd_t cmd_hold;
  logic rsp_valid;
  rsp_t rsp_data;

  logic     advance;
  logic     cfg_write;
  reg_idx_t reg_idx;

  logic [BandProdW-1:0] band_prod;
  logic [StepW-1:0]     band_raw;
  logic [StepW-1:0]     band;
  logic                 below_band;
  logic                 above_band;
  logic [CurW:0]        plus_sum;

  // APB write decode
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      panic_threshold <= PANIC_THRESHOLD_RST;
      encoder_limit   <= ENCODER_LIMIT_RST;
      serial_limit    <= SERIAL_LIMIT_RST;
      serial_step     <= SERIAL_STEP_RST;
      min_band        <= MIN_BAND_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_PANIC_THRESHOLD: panic_threshold <= pwdata[CurW-1:0];
        REG_ENCODER_LIMIT:   encoder_limit   <= pwdata[CurW-1:0];
        REG_SERIAL_LIMIT:    serial_limit    <= pwdata[CurW-1:0];
        REG_SERIAL_STEP:     serial_step     <= pwdata[StepW-1:0];
        REG_MIN_BAND:        min_band        <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  // APB read mux
  always_comb begin
    case (reg_idx)
      REG_PANIC_THRESHOLD: prdata = 32'(panic_threshold);
      REG_ENCODER_LIMIT:   prdata = 32'(encoder_limit);
      REG_SERIAL_LIMIT:    prdata = 32'(serial_limit);
      REG_SERIAL_STEP:     prdata = 32'(serial_step);
      REG_MIN_BAND:        prdata = 32'(min_band);
      default:             prdata = 32'd0;
    endcase
  end

  // Handshake: advance when the response slot is free or being drained
  assign advance   = !rsp_valid || rsp.ready;
  assign cmd.ready = !hold_valid || advance;

  // Capture the command transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.ready) begin
      hold_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      cmd_hold.op          <= cmd.op;
      cmd_hold.up          <= cmd.up;
      cmd_hold.rx_byte     <= cmd.rx_byte;
      cmd_hold.current     <= cmd.current;
      cmd_hold.raw_current <= cmd.raw_current;
    end
  end

  // Deadband half-width: setpoint / 20 by reciprocal multiply, floored at min_band
  assign band_prod = BandProdW'(setpoint) * BandProdW'(BAND_RECIP);
  assign band_raw  = band_prod[BandProdW-1:16];
  assign band      = (band_raw < min_band) ? min_band : band_raw;

  assign below_band = {1'b0, setpoint} > ((CurW+1)'(cmd_hold.current) + (CurW+1)'(band));
  assign above_band = ((CurW+1)'(setpoint) + (CurW+1)'(band)) < {1'b0, cmd_hold.current};
  assign plus_sum   = (CurW+1)'(setpoint) + (CurW+1)'(serial_step);

  // Next state for the held command
  always_comb begin
    setpoint_next = setpoint;
    duty_next     = duty;
    case (cmd_hold.op)
      OP_TICK: begin
        if (setpoint == '0) begin
          duty_next = '0;
        end else if (!duty[DutyW-1] && below_band) begin
          duty_next = duty + DutyW'(1);
        end else if (duty != '0 && above_band) begin
          duty_next = duty - DutyW'(1);
        end
      end
      OP_ENC: begin
        if (cmd_hold.up) begin
          if (setpoint < encoder_limit) setpoint_next = setpoint + CurW'(1);
        end else if (setpoint != '0) begin
          setpoint_next = setpoint - CurW'(1);
        end
      end
      OP_SERIAL: begin
        case (cmd_hold.rx_byte)
          CHAR_PLUS: begin
            if (setpoint < serial_limit) begin
              setpoint_next = plus_sum[CurW] ? SP_MAX : plus_sum[CurW-1:0];
            end
          end
          CHAR_MINUS: begin
            setpoint_next = (setpoint > CurW'(serial_step)) ?
                            setpoint - CurW'(serial_step) : '0;
          end
          default: ;
        endcase
      end
      OP_RAW: begin
        if (cmd_hold.raw_current > panic_threshold) duty_next = '0;
      end
      default: ;
    endcase
  end

  // Commit state and load the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint  <= SETPOINT_RST;
      duty      <= DUTY_RST;
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= hold_valid;
      if (hold_valid) begin
        setpoint <= setpoint_next;
        duty     <= duty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      rsp_data.duty         <= duty_next;
      rsp_data.pwm_on       <= (duty_next != '0);
      rsp_data.setpoint_out <= setpoint_next;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.duty         = rsp_data.duty;
  assign rsp.pwm_on       = rsp_data.pwm_on;
  assign rsp.setpoint_out = rsp_data.setpoint_out;

endmodule
